/* rtl/core/ihlf_pkg.sv */
package ihlf_pkg;

   // Matrix geometry and storage layout.
   localparam int MAX_N       = 4;
   localparam int IDX_W       = 2;
   localparam int STORE_DEPTH = MAX_N * MAX_N;
   localparam int CNT_W       = 5;
   localparam int K_W         = 4;
   localparam int DATA_W      = 32;
   localparam int IN_W        = 16;
   localparam int SIZE_W      = 3;
   localparam int ADDR_W      = 6;
   localparam int RAM_DEPTH   = 64;
   localparam int STEP_W      = 9;
   localparam int DIV_CNT_W   = 6;

   localparam logic [STEP_W-1:0]    STEP_CAP    = 9'd256;
   localparam logic [CNT_W-1:0]     STORE_LIMIT = 5'd16;
   localparam logic [DIV_CNT_W-1:0] DIV_STEPS   = 6'd32;

   // Regions of the shared word store.
   localparam logic [1:0] REG_H   = 2'b00;
   localparam logic [1:0] REG_U   = 2'b01;
   localparam logic [1:0] REG_RAW = 2'b10;

   typedef enum logic [4:0] {
      S_LOAD, S_INIT_RD, S_INIT_WH, S_INIT_WU,
      S_NEG_RD, S_NEG_CHK, S_NEGH_RD, S_NEGH_WR, S_NEGU_RD, S_NEGU_WR,
      S_SCAN_RD, S_SCAN_CHK, S_DECIDE,
      S_SWH_RD, S_SWH_W1, S_SWH_W2, S_SWU_RD, S_SWU_W1, S_SWU_W2,
      S_DIV_RD, S_DIV_GO, S_DIV_WAIT,
      S_MH_RD, S_MH_MUL, S_MH_WR, S_MU_RD, S_MU_MUL, S_MU_WR,
      S_EMIT
   } ctl_state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_COPY, OP_IDENT, OP_NEG, OP_WR_A, OP_WR_B,
      OP_SCAN, OP_DIV, OP_MUL, OP_MAC, OP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type         op;
      logic [ADDR_W-1:0] rd_addr_a;
      logic [ADDR_W-1:0] rd_addr_b;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic              gate_zero;
      logic              ident;
      logic              sub;
      logic              clr_ovf;
      logic              set_ovf;
      logic              scan_first;
      logic              scan_later;
      logic [IDX_W-1:0]  scan_idx;
      logic              tag_sel;
      logic [IDX_W-1:0]  tag_row;
      logic [IDX_W-1:0]  tag_col;
      logic              tag_last;
   } dp_cmd_type;

   typedef struct packed {
      logic             neg_a;
      logic             zero_b;
      logic             more;
      logic [IDX_W-1:0] min_idx;
      logic             div_done;
   } dp_status_type;

   // Word address of an H or U entry.
   function automatic logic [ADDR_W-1:0] mk_addr(input logic [1:0] region,
                                                 input logic [IDX_W-1:0] row,
                                                 input logic [IDX_W-1:0] col);
      mk_addr = {region, row, col};
   endfunction

endpackage

/* rtl/core/ihlf_ram.sv */
// Generic RAM: one write port, two read ports, registered read-first data.
module ihlf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Reads see the contents from before a write at the same edge.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

/* rtl/core/ihlf_div.sv */
// Signed 32-bit divider, quotient truncated toward zero, one bit per cycle.
module ihlf_div import ihlf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] num,
   input  logic [DATA_W-1:0] den,
   output logic              done,
   output logic [DATA_W-1:0] quot,
   output logic              ovf
);

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DATA_W-1:0]    dvd_ff, dvd_in;
   logic [DATA_W-1:0]    dvs_ff, dvs_in;
   logic [DATA_W:0]      rem_ff, rem_in;
   logic                 neg_ff, neg_in;
   logic [DATA_W:0]      rem_sh;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
   end

   // Restoring division on magnitudes; the quotient shifts into the dividend.
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      neg_in  = neg_ff;
      done    = 1'b0;
      rem_sh  = {rem_ff[DATA_W-1:0], dvd_ff[DATA_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_STEPS;
         dvd_in  = num[DATA_W-1] ? (~num + 1'b1) : num;
         dvs_in  = den[DATA_W-1] ? (~den + 1'b1) : den;
         rem_in  = '0;
         neg_in  = num[DATA_W-1] ^ den[DATA_W-1];
      end else if (busy_ff && cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = rem_sh - {1'b0, dvs_ff};
            dvd_in = {dvd_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            dvd_in = {dvd_ff[DATA_W-2:0], 1'b0};
         end
      end else if (busy_ff) begin
         busy_in = 1'b0;
         done    = 1'b1;
      end
   end

   // A positive quotient of two to the 31st does not fit.
   assign quot = neg_ff ? (~dvd_ff + 1'b1) : dvd_ff;
   assign ovf  = ~neg_ff & dvd_ff[DATA_W-1];

endmodule

/* rtl/core/ihlf_dp.sv */
// Datapath: word store, negation, scan, divider, multiply-add and result word.
module ihlf_dp import ihlf_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  dp_cmd_type               cmd,
   input  logic signed [IN_W-1:0]   load_value,
   output dp_status_type            status,
   output logic                     rsp_valid,
   output logic                     rsp_matrix_select,
   output logic [IDX_W-1:0]         rsp_row_index,
   output logic [IDX_W-1:0]         rsp_col_index,
   output logic signed [DATA_W-1:0] rsp_entry_value,
   output logic                     rsp_overflow,
   output logic                     rsp_last_result
);

   logic [DATA_W-1:0]        rd_a, rd_b, wr_data;
   logic                     ovf_ff, ovf_in;
   logic signed [DATA_W-1:0] min_val_ff, min_val_in;
   logic [IDX_W-1:0]         min_idx_ff, min_idx_in;
   logic                     min_ok_ff, min_ok_in;
   logic                     more_ff, more_in;
   logic signed [DATA_W-1:0] f_ff, f_in;
   logic signed [63:0]       prod_ff, prod_in;
   logic signed [63:0]       mac;
   logic                     mac_ovf;
   logic                     div_done, div_ovf;
   logic [DATA_W-1:0]        div_quot;
   logic                     emit_ff;
   logic                     sel_ff;
   logic [IDX_W-1:0]         row_ff, col_ff;
   logic                     last_ff;

   ihlf_ram #(.WIDTH(DATA_W), .DEPTH(RAM_DEPTH)) u_ram (
      .clock     (clock),
      .wr_en     (cmd.wr_en),
      .wr_addr   (cmd.wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (cmd.rd_addr_a),
      .rd_data_a (rd_a),
      .rd_addr_b (cmd.rd_addr_b),
      .rd_data_b (rd_b)
   );

   ihlf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.op == OP_DIV && rd_b != '0),
      .num   (rd_a),
      .den   (rd_b),
      .done  (div_done),
      .quot  (div_quot),
      .ovf   (div_ovf)
   );

   // Multiply-add on a product registered the cycle before.
   always_comb begin
      if (cmd.sub) begin
         mac = $signed({{32{rd_a[DATA_W-1]}}, rd_a}) - prod_ff;
      end else begin
         mac = $signed({{32{rd_a[DATA_W-1]}}, rd_a}) + prod_ff;
      end
      mac_ovf = (mac[63:31] != '0) && (mac[63:31] != '1);
   end

   // Write word selection.
   always_comb begin
      case (cmd.op)
         OP_LOAD:  wr_data = {{(DATA_W-IN_W){load_value[IN_W-1]}}, load_value};
         OP_COPY:  wr_data = cmd.gate_zero ? '0 : rd_a;
         OP_IDENT: wr_data = {{(DATA_W-1){1'b0}}, cmd.ident};
         OP_NEG:   wr_data = ~rd_a + 1'b1;
         OP_WR_A:  wr_data = rd_a;
         OP_WR_B:  wr_data = rd_b;
         OP_MAC:   wr_data = mac[DATA_W-1:0];
         default:  wr_data = '0;
      endcase
   end

   // Scan, quotient, product and sticky overflow updates.
   always_comb begin
      ovf_in     = ovf_ff;
      min_val_in = min_val_ff;
      min_idx_in = min_idx_ff;
      min_ok_in  = min_ok_ff;
      more_in    = more_ff;
      f_in       = f_ff;
      prod_in    = prod_ff;
      if (cmd.op == OP_SCAN) begin
         if (cmd.scan_first) begin
            min_ok_in  = rd_a != '0;
            min_val_in = $signed(rd_a);
            min_idx_in = cmd.scan_idx;
            more_in    = 1'b0;
         end else begin
            if (rd_a != '0 && (!min_ok_ff || $signed(rd_a) < min_val_ff)) begin
               min_ok_in  = 1'b1;
               min_val_in = $signed(rd_a);
               min_idx_in = cmd.scan_idx;
            end
            if (cmd.scan_later && rd_a != '0) begin
               more_in = 1'b1;
            end
         end
      end
      if (cmd.op == OP_MUL) begin
         prod_in = f_ff * $signed(rd_b);
      end
      if (div_done) begin
         f_in = $signed(div_quot);
         if (div_ovf) begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.op == OP_NEG && rd_a == {1'b1, {(DATA_W-1){1'b0}}}) begin
         ovf_in = 1'b1;
      end
      if (cmd.op == OP_MAC && mac_ovf) begin
         ovf_in = 1'b1;
      end
      if (cmd.set_ovf) begin
         ovf_in = 1'b1;
      end
      if (cmd.clr_ovf) begin
         ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovf_ff  <= 1'b0;
         emit_ff <= 1'b0;
      end else begin
         ovf_ff  <= ovf_in;
         emit_ff <= cmd.op == OP_EMIT;
      end
      min_val_ff <= min_val_in;
      min_idx_ff <= min_idx_in;
      min_ok_ff  <= min_ok_in;
      more_ff    <= more_in;
      f_ff       <= f_in;
      prod_ff    <= prod_in;
      sel_ff     <= cmd.tag_sel;
      row_ff     <= cmd.tag_row;
      col_ff     <= cmd.tag_col;
      last_ff    <= cmd.tag_last;
   end

   assign status.neg_a    = rd_a[DATA_W-1];
   assign status.zero_b   = rd_b == '0;
   assign status.more     = more_ff;
   assign status.min_idx  = min_idx_ff;
   assign status.div_done = div_done;

   // The result word comes straight from the registered read port.
   assign rsp_valid         = emit_ff;
   assign rsp_matrix_select = sel_ff;
   assign rsp_row_index     = row_ff;
   assign rsp_col_index     = col_ff;
   assign rsp_entry_value   = $signed(rd_a);
   assign rsp_overflow      = ovf_ff;
   assign rsp_last_result   = last_ff;

endmodule

/* rtl/core/ihlf_ctrl.sv */
// Controller: load counting, the column-operation sequence and the emit sweep.
module ihlf_ctrl import ihlf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              last_element,
   output logic              busy,
   input  logic              csr_valid,
   input  logic [SIZE_W-1:0] csr_matrix_size,
   output dp_cmd_type        cmd,
   input  dp_status_type     status
);

   ctl_state_type      state_ff, state_in;
   logic [SIZE_W-1:0]  size_ff, size_in;
   logic [IDX_W-1:0]   nm1_ff, nm1_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [K_W-1:0]     k_ff, k_in;
   logic [IDX_W-1:0]   r_ff, r_in, c_ff, c_in;
   logic [IDX_W-1:0]   i_ff, i_in, j_ff, j_in, t_ff, t_in;
   logic [STEP_W-1:0]  steps_ff, steps_in;
   logic               sel_ff, sel_in;
   logic [IDX_W-1:0]   m;

   assign m    = status.min_idx;
   assign busy = state_ff != S_LOAD;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         size_ff  <= SIZE_W'(MAX_N);
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         size_ff  <= size_in;
         cnt_ff   <= cnt_in;
      end
      nm1_ff   <= nm1_in;
      k_ff     <= k_in;
      r_ff     <= r_in;
      c_ff     <= c_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      t_ff     <= t_in;
      steps_ff <= steps_in;
      sel_ff   <= sel_in;
   end

   always_comb begin
      state_in = state_ff;
      size_in  = csr_valid ? csr_matrix_size : size_ff;
      nm1_in   = nm1_ff;
      cnt_in   = cnt_ff;
      k_in     = k_ff;
      r_in     = r_ff;
      c_in     = c_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      t_in     = t_ff;
      steps_in = steps_ff;
      sel_in   = sel_ff;
      cmd      = '0;
      cmd.op   = OP_NONE;

      case (state_ff)
         // Entries go to the raw region; the mark fixes the size in force.
         S_LOAD: begin
            if (start) begin
               if (cnt_ff < STORE_LIMIT) begin
                  cmd.op      = OP_LOAD;
                  cmd.wr_en   = 1'b1;
                  cmd.wr_addr = {REG_RAW, cnt_ff[K_W-1:0]};
                  cnt_in      = cnt_ff + 1'b1;
               end
               if (last_element) begin
                  cmd.clr_ovf = 1'b1;
                  if (size_ff == '0) begin
                     nm1_in = '0;
                  end else if (size_ff >= SIZE_W'(MAX_N)) begin
                     nm1_in = IDX_W'(MAX_N - 1);
                  end else begin
                     nm1_in = IDX_W'(size_ff - 1'b1);
                  end
                  k_in     = '0;
                  r_in     = '0;
                  c_in     = '0;
                  state_in = S_INIT_RD;
               end
            end
         end

         // H takes the received entries, U starts as identity.
         S_INIT_RD: begin
            cmd.rd_addr_a = {REG_RAW, k_ff};
            state_in      = S_INIT_WH;
         end
         S_INIT_WH: begin
            cmd.rd_addr_a = {REG_RAW, k_ff};
            cmd.op        = OP_COPY;
            cmd.gate_zero = {1'b0, k_ff} >= cnt_ff;
            cmd.wr_en     = 1'b1;
            cmd.wr_addr   = mk_addr(REG_H, r_ff, c_ff);
            state_in      = S_INIT_WU;
         end
         S_INIT_WU: begin
            cmd.op      = OP_IDENT;
            cmd.ident   = r_ff == c_ff;
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = mk_addr(REG_U, r_ff, c_ff);
            k_in        = k_ff + 1'b1;
            state_in    = S_INIT_RD;
            if (c_ff == nm1_ff) begin
               c_in = '0;
               if (r_ff == nm1_ff) begin
                  j_in     = '0;
                  i_in     = '0;
                  steps_in = '0;
                  state_in = S_NEG_RD;
               end else begin
                  r_in = r_ff + 1'b1;
               end
            end else begin
               c_in = c_ff + 1'b1;
            end
         end

         // Negate each column of H whose pivot-row entry is negative, and the same row of U.
         S_NEG_RD: begin
            cmd.rd_addr_a = mk_addr(REG_H, j_ff, i_ff);
            state_in      = S_NEG_CHK;
         end
         S_NEG_CHK: begin
            cmd.rd_addr_a = mk_addr(REG_H, j_ff, i_ff);
            r_in          = '0;
            if (status.neg_a) begin
               state_in = S_NEGH_RD;
            end else if (i_ff == nm1_ff) begin
               t_in     = j_ff;
               state_in = S_SCAN_RD;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = S_NEG_RD;
            end
         end
         S_NEGH_RD: begin
            cmd.rd_addr_a = mk_addr(REG_H, r_ff, i_ff);
            state_in      = S_NEGH_WR;
         end
         S_NEGH_WR: begin
            cmd.rd_addr_a = mk_addr(REG_H, r_ff, i_ff);
            cmd.op        = OP_NEG;
            cmd.wr_en     = 1'b1;
            cmd.wr_addr   = mk_addr(REG_H, r_ff, i_ff);
            state_in      = S_NEGH_RD;
            if (r_ff == nm1_ff) begin
               c_in     = '0;
               state_in = S_NEGU_RD;
            end else begin
               r_in = r_ff + 1'b1;
            end
         end
         S_NEGU_RD: begin
            cmd.rd_addr_a = mk_addr(REG_U, i_ff, c_ff);
            state_in      = S_NEGU_WR;
         end
         S_NEGU_WR: begin
            cmd.rd_addr_a = mk_addr(REG_U, i_ff, c_ff);
            cmd.op        = OP_NEG;
            cmd.wr_en     = 1'b1;
            cmd.wr_addr   = mk_addr(REG_U, i_ff, c_ff);
            state_in      = S_NEGU_RD;
            if (c_ff == nm1_ff) begin
               if (i_ff == nm1_ff) begin
                  t_in     = j_ff;
                  state_in = S_SCAN_RD;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = S_NEG_RD;
               end
            end else begin
               c_in = c_ff + 1'b1;
            end
         end

         // Find the smallest nonzero entry and whether reduction remains.
         S_SCAN_RD: begin
            cmd.rd_addr_a = mk_addr(REG_H, j_ff, t_ff);
            state_in      = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            cmd.rd_addr_a  = mk_addr(REG_H, j_ff, t_ff);
            cmd.op         = OP_SCAN;
            cmd.scan_first = t_ff == j_ff;
            cmd.scan_later = t_ff != j_ff;
            cmd.scan_idx   = t_ff;
            if (t_ff == nm1_ff) begin
               state_in = S_DECIDE;
            end else begin
               t_in     = t_ff + 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         S_DECIDE: begin
            if (status.more && steps_ff != STEP_CAP) begin
               steps_in = steps_ff + 1'b1;
               r_in     = '0;
               state_in = S_SWH_RD;
            end else begin
               cmd.set_ovf = status.more;
               steps_in    = '0;
               if (j_ff == nm1_ff) begin
                  sel_in   = 1'b0;
                  r_in     = '0;
                  c_in     = '0;
                  state_in = S_EMIT;
               end else begin
                  j_in     = j_ff + 1'b1;
                  i_in     = j_ff + 1'b1;
                  state_in = S_NEG_RD;
               end
            end
         end

         // Swap column j with the minimum's column, and the same rows of U.
         S_SWH_RD, S_SWH_W1, S_SWH_W2: begin
            cmd.rd_addr_a = mk_addr(REG_H, r_ff, j_ff);
            cmd.rd_addr_b = mk_addr(REG_H, r_ff, m);
            if (state_ff == S_SWH_RD) begin
               state_in = S_SWH_W1;
            end else if (state_ff == S_SWH_W1) begin
               cmd.op      = OP_WR_B;
               cmd.wr_en   = 1'b1;
               cmd.wr_addr = mk_addr(REG_H, r_ff, j_ff);
               state_in    = S_SWH_W2;
            end else begin
               cmd.op      = OP_WR_A;
               cmd.wr_en   = 1'b1;
               cmd.wr_addr = mk_addr(REG_H, r_ff, m);
               state_in    = S_SWH_RD;
               if (r_ff == nm1_ff) begin
                  c_in     = '0;
                  state_in = S_SWU_RD;
               end else begin
                  r_in = r_ff + 1'b1;
               end
            end
         end
         S_SWU_RD, S_SWU_W1, S_SWU_W2: begin
            cmd.rd_addr_a = mk_addr(REG_U, j_ff, c_ff);
            cmd.rd_addr_b = mk_addr(REG_U, m, c_ff);
            if (state_ff == S_SWU_RD) begin
               state_in = S_SWU_W1;
            end else if (state_ff == S_SWU_W1) begin
               cmd.op      = OP_WR_B;
               cmd.wr_en   = 1'b1;
               cmd.wr_addr = mk_addr(REG_U, j_ff, c_ff);
               state_in    = S_SWU_W2;
            end else begin
               cmd.op      = OP_WR_A;
               cmd.wr_en   = 1'b1;
               cmd.wr_addr = mk_addr(REG_U, m, c_ff);
               state_in    = S_SWU_RD;
               if (c_ff == nm1_ff) begin
                  i_in     = j_ff + 1'b1;
                  state_in = S_DIV_RD;
               end else begin
                  c_in = c_ff + 1'b1;
               end
            end
         end

         // Quotient of a later entry by the pivot.
         S_DIV_RD, S_DIV_GO, S_DIV_WAIT: begin
            cmd.rd_addr_a = mk_addr(REG_H, j_ff, i_ff);
            cmd.rd_addr_b = mk_addr(REG_H, j_ff, j_ff);
            if (state_ff == S_DIV_RD) begin
               state_in = S_DIV_GO;
            end else if (state_ff == S_DIV_GO) begin
               cmd.op = OP_DIV;
               if (status.zero_b) begin
                  t_in     = j_ff;
                  state_in = S_SCAN_RD;
               end else begin
                  state_in = S_DIV_WAIT;
               end
            end else if (status.div_done) begin
               r_in     = '0;
               state_in = S_MH_RD;
            end
         end

         // Column i of H loses f times column j.
         S_MH_RD, S_MH_MUL, S_MH_WR: begin
            cmd.rd_addr_a = mk_addr(REG_H, r_ff, i_ff);
            cmd.rd_addr_b = mk_addr(REG_H, r_ff, j_ff);
            cmd.sub       = 1'b1;
            if (state_ff == S_MH_RD) begin
               state_in = S_MH_MUL;
            end else if (state_ff == S_MH_MUL) begin
               cmd.op   = OP_MUL;
               state_in = S_MH_WR;
            end else begin
               cmd.op      = OP_MAC;
               cmd.wr_en   = 1'b1;
               cmd.wr_addr = mk_addr(REG_H, r_ff, i_ff);
               state_in    = S_MH_RD;
               if (r_ff == nm1_ff) begin
                  c_in     = '0;
                  state_in = S_MU_RD;
               end else begin
                  r_in = r_ff + 1'b1;
               end
            end
         end

         // Row j of U gains f times row i.
         S_MU_RD, S_MU_MUL, S_MU_WR: begin
            cmd.rd_addr_a = mk_addr(REG_U, j_ff, c_ff);
            cmd.rd_addr_b = mk_addr(REG_U, i_ff, c_ff);
            if (state_ff == S_MU_RD) begin
               state_in = S_MU_MUL;
            end else if (state_ff == S_MU_MUL) begin
               cmd.op   = OP_MUL;
               state_in = S_MU_WR;
            end else begin
               cmd.op      = OP_MAC;
               cmd.wr_en   = 1'b1;
               cmd.wr_addr = mk_addr(REG_U, j_ff, c_ff);
               state_in    = S_MU_RD;
               if (c_ff == nm1_ff) begin
                  if (i_ff == nm1_ff) begin
                     t_in     = j_ff;
                     state_in = S_SCAN_RD;
                  end else begin
                     i_in     = i_ff + 1'b1;
                     state_in = S_DIV_RD;
                  end
               end else begin
                  c_in = c_ff + 1'b1;
               end
            end
         end

         // One read a cycle; the word appears the cycle after.
         S_EMIT: begin
            cmd.rd_addr_a = mk_addr(sel_ff ? REG_U : REG_H, r_ff, c_ff);
            cmd.op        = OP_EMIT;
            cmd.tag_sel   = sel_ff;
            cmd.tag_row   = r_ff;
            cmd.tag_col   = c_ff;
            cmd.tag_last  = sel_ff && r_ff == nm1_ff && c_ff == nm1_ff;
            if (c_ff == nm1_ff) begin
               c_in = '0;
               if (r_ff == nm1_ff) begin
                  r_in = '0;
                  if (sel_ff) begin
                     cnt_in   = '0;
                     state_in = S_LOAD;
                  end else begin
                     sel_in = 1'b1;
                  end
               end else begin
                  r_in = r_ff + 1'b1;
               end
            end else begin
               c_in = c_ff + 1'b1;
            end
         end

         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

endmodule

/* rtl/core/integer_hermite_lower_form.sv */
// Loading takes one entry per cycle while start is high; busy stays low until the marked entry.
// Compute then runs for a data-dependent time: each reduction quotient passes
// through the bit-serial divider; row and column updates read, multiply, write.
// Results follow back to back, 2*n*n words, the last one in the cycle busy drops.
// Synchronous reset clears the controller and sets matrix_size to 4.
// The receiver cannot stall; each result word is shown for one cycle.
module integer_hermite_lower_form import ihlf_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [IN_W-1:0]   req_element_value,
   input  logic                     req_last_element,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [SIZE_W-1:0]        csr_matrix_size,
   output logic                     rsp_valid,
   output logic                     rsp_matrix_select,
   output logic [IDX_W-1:0]         rsp_row_index,
   output logic [IDX_W-1:0]         rsp_col_index,
   output logic signed [DATA_W-1:0] rsp_entry_value,
   output logic                     rsp_overflow,
   output logic                     rsp_last_result
);

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   ihlf_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .last_element    (req_last_element),
      .busy            (busy),
      .csr_valid       (csr_valid),
      .csr_matrix_size (csr_matrix_size),
      .cmd             (cmd),
      .status          (status)
   );

   ihlf_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .load_value        (req_element_value),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_matrix_select (rsp_matrix_select),
      .rsp_row_index     (rsp_row_index),
      .rsp_col_index     (rsp_col_index),
      .rsp_entry_value   (rsp_entry_value),
      .rsp_overflow      (rsp_overflow),
      .rsp_last_result   (rsp_last_result)
   );

endmodule

/* rtl/core/ihlf_checker.sv */
// Port-level checks of the result sequence.
module ihlf_checker import ihlf_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input logic signed [IN_W-1:0]   req_element_value,
   input logic                     req_last_element,
   input logic                     csr_valid,
   input logic                     csr_ready,
   input logic [SIZE_W-1:0]        csr_matrix_size,
   input logic                     rsp_valid,
   input logic                     rsp_matrix_select,
   input logic [IDX_W-1:0]         rsp_row_index,
   input logic [IDX_W-1:0]         rsp_col_index,
   input logic signed [DATA_W-1:0] rsp_entry_value,
   input logic                     rsp_overflow,
   input logic                     rsp_last_result
);

   // The marked entry starts a run.
   a_mark_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_last_element |=> busy)
      else $error("run did not start after the marked entry");

   // Words of a run come without gaps until the last one.
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_result |=> rsp_valid)
      else $error("gap in the result words");

   // A run opens with the first H entry.
   a_first: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !rsp_matrix_select && rsp_row_index == '0 &&
                           rsp_col_index == '0)
      else $error("run does not open at H entry zero");

   // The overflow flag is the same on every word of a run.
   a_ovf_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(rsp_valid) |-> $stable(rsp_overflow))
      else $error("overflow flag changed within a run");

endmodule

bind integer_hermite_lower_form ihlf_checker u_ihlf_checker (.*);
